@@ hw/rtl/b2d_pkg.sv @@
// ----------------------------------------------------------------------------
// b2d_pkg
// Types, constants and the shift-add-3 step shared by the converter files.
// ----------------------------------------------------------------------------
package b2d_pkg;

    localparam int VALUE_W    = 32;
    localparam int MIN_W      = 4;
    localparam int CHAR_W     = 6;
    localparam int BCD_DIGITS = 10;                 // 32-bit value needs ten digits
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int DIGIT_IW   = $clog2(BCD_DIGITS);
    localparam int STAGE_BITS = 8;                  // source bits handled per stage
    localparam int NUM_STAGES = VALUE_W / STAGE_BITS;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [MIN_W-1:0]   min_digits;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
    } out_t;

    // Working word of the converter: BCD accumulator, remaining binary bits, min digits.
    typedef struct packed {
        logic [BCD_DIGITS-1:0][3:0] bcd;
        logic [VALUE_W-1:0]         bin;
        logic [MIN_W-1:0]           min_digits;
    } conv_t;

    // STAGE_BITS rounds of add-3 then shift.
    function automatic conv_t dabble_step(conv_t s);
        conv_t            r;
        logic [BCD_W:0]   sh;
        r = s;
        for (int i = 0; i < STAGE_BITS; i++)
        begin
            for (int j = 0; j < BCD_DIGITS; j++)
            begin
                if (r.bcd[j] >= 4'd5)
                begin
                    r.bcd[j] = r.bcd[j] + 4'd3;
                end
            end
            sh    = {r.bcd, r.bin[VALUE_W-1]};
            r.bcd = sh[BCD_W-1:0];
            r.bin = {r.bin[VALUE_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/b2d_stage.sv @@
// ----------------------------------------------------------------------------
// b2d_stage
// One register stage of the double-dabble pipeline.
// ----------------------------------------------------------------------------
module b2d_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  logic           in_valid,
    input  b2d_pkg::conv_t in_data,
    output logic           out_valid,
    output b2d_pkg::conv_t out_data
);

    logic           valid_reg;
    b2d_pkg::conv_t data_reg;
    b2d_pkg::conv_t data_next;

    assign data_next = b2d_pkg::dabble_step(in_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/b2d_serializer.sv @@
// ----------------------------------------------------------------------------
// b2d_serializer
// Sizes the digit count and emits one ASCII digit per cycle, MSD first.
// ----------------------------------------------------------------------------
module b2d_serializer #(
    parameter int MAX_DIGITS = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  b2d_pkg::conv_t in_data,
    output logic           ready,
    output logic           strobe,
    output b2d_pkg::out_t  result
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int PW = $clog2(MAX_DIGITS);

    logic                               active_reg, active_next;
    logic [PW-1:0]                      pos_reg, pos_next;
    logic [b2d_pkg::BCD_DIGITS-1:0][3:0] bcd_reg;
    logic                               strobe_reg;
    b2d_pkg::out_t                      result_reg, result_next;
    logic                               load;
    logic [CW-1:0]                      nat_len;
    logic [CW-1:0]                      count;
    logic [3:0]                         digit;

    assign ready = !active_reg || (pos_reg == '0);
    assign load  = in_valid && ready;

    // Natural length: index of the top nonzero digit plus one, at least one.
    always_comb
    begin
        nat_len = CW'(1);
        for (int j = 0; j < b2d_pkg::BCD_DIGITS; j++)
        begin
            if (in_data.bcd[j] != 4'd0)
            begin
                nat_len = CW'(j + 1);
            end
        end
        count = nat_len;
        if (CW'(in_data.min_digits) > count)
        begin
            count = CW'(in_data.min_digits);
        end
        if (count > CW'(MAX_DIGITS))
        begin
            count = CW'(MAX_DIGITS);
        end
    end

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        if (active_reg)
        begin
            if (pos_reg == '0)
            begin
                active_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg - PW'(1);
            end
        end
        if (load)
        begin
            active_next = 1'b1;
            pos_next    = PW'(count - CW'(1));
        end
    end

    // Positions above the BCD width are padding zeros.
    always_comb
    begin
        if (pos_reg < PW'(b2d_pkg::BCD_DIGITS))
        begin
            digit = bcd_reg[pos_reg[b2d_pkg::DIGIT_IW-1:0]];
        end
        else
        begin
            digit = 4'd0;
        end
        result_next.digit_char = b2d_pkg::ASCII_ZERO + {2'b00, digit};
        result_next.last_digit = (pos_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            strobe_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bcd_reg <= in_data.bcd;
        end
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

@@ hw/rtl/binary_to_decimal_ascii.sv @@
// Path: a number passes the converter stages, emitter state and output register;
//   it waits on a busy emitter, and its digits then strobe without gaps.
// Throughput: a number takes 1..MAX_DIGITS digits on the single-digit-per-cycle
//   result port, and the next can load on its last digit; the 4-stage converter
//   can take a beat every cycle while the emitter keeps up.
// Reset: rst_n clears all valid bits and the emitter; no strobe after reset.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// 32-bit binary to ASCII decimal: pipelined double dabble plus digit emitter.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
    parameter int MAX_DIGITS = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  b2d_pkg::in_t  operand,
    output logic          strobe,
    output b2d_pkg::out_t result
);

    localparam int NS = b2d_pkg::NUM_STAGES;

    // Stage k holds the word after (k+1)*STAGE_BITS shift-add rounds.
    logic           s_valid [NS];
    b2d_pkg::conv_t s_data  [NS];
    logic           s_ready [NS];
    logic           ser_ready;
    b2d_pkg::conv_t head;

    // Incoming beat: empty BCD accumulator, value to be shifted out MSB first.
    always_comb
    begin
        head.bcd        = '0;
        head.bin        = operand.value;
        head.min_digits = operand.min_digits;
    end

    // A stage may load when it is empty or its contents move on this cycle.
    generate
        for (genvar k = 0; k < NS; k++)
        begin : g_stage
            if (k == NS - 1)
            begin : g_tail
                assign s_ready[k] = !s_valid[k] || ser_ready;
            end
            else
            begin : g_mid
                assign s_ready[k] = !s_valid[k] || s_ready[k+1];
            end

            if (k == 0)
            begin : g_first
                b2d_stage u_stage (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .load      (s_ready[k]),
                    .in_valid  (start),
                    .in_data   (head),
                    .out_valid (s_valid[k]),
                    .out_data  (s_data[k])
                );
            end
            else
            begin : g_next
                b2d_stage u_stage (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .load      (s_ready[k]),
                    .in_valid  (s_valid[k-1]),
                    .in_data   (s_data[k-1]),
                    .out_valid (s_valid[k]),
                    .out_data  (s_data[k])
                );
            end
        end
    endgenerate

    assign busy = !s_ready[0];

    // Emitter: sizes the count and walks the digits down to the last one.
    b2d_serializer #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_valid[NS-1]),
        .in_data  (s_data[NS-1]),
        .ready    (ser_ready),
        .strobe   (strobe),
        .result   (result)
    );

    // Digits of one number come out without gaps.
    a_digits_contiguous : assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last_digit |=> strobe)
        else $error("digit stream broke before the last digit");

    // Every emitted character is a decimal digit.
    a_digit_range : assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (result.digit_char >= 6'd48 && result.digit_char <= 6'd57))
        else $error("emitted character is not a decimal digit");

    // Back-pressure only arises with the first stage occupied.
    a_busy_needs_data : assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> s_valid[0])
        else $error("busy raised with an empty pipeline head");

endmodule
